[rtl/core/all_pkg.sv]
`timescale 1ns / 1ps

package all_pkg;

   localparam int COUNT_BITS = 5;
   localparam int POS_BITS   = 4;
   localparam int SLOT_BITS_OUT = 4;
   localparam int ITEM_BITS  = 32;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_code_type;

   typedef struct packed {
      logic                        opcode;
      logic signed [ITEM_BITS-1:0] item_value;
      logic [POS_BITS-1:0]         list_position;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [SLOT_BITS_OUT-1:0] slot_used;
      logic [COUNT_BITS-1:0]    list_length;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic            load;
      logic            scan_step;
      logic            walk_step;
      logic            append_commit;
      logic            remove_commit;
      logic            respond;
      status_code_type code;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_remove;
      logic full;
      logic bad_pos;
      logic slot_free;
      logic scan_last;
      logic at_target;
   } flags_type;

endpackage

[rtl/core/all_ctrl.sv]
`timescale 1ns / 1ps

module all_ctrl
   import all_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  flags_type flags,
   output cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECIDE = 4'b0010,
      S_SCAN   = 4'b0100,
      S_WALK   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.code = ST_DONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!flags.is_remove) begin
               if (flags.full) begin
                  cmd.respond = 1'b1;
                  cmd.code    = ST_FULL;
                  state_in    = S_IDLE;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               if (flags.bad_pos) begin
                  cmd.respond = 1'b1;
                  cmd.code    = ST_RANGE;
                  state_in    = S_IDLE;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_SCAN: begin
            if (flags.slot_free) begin
               cmd.append_commit = 1'b1;
               cmd.respond       = 1'b1;
               state_in          = S_IDLE;
            end else if (flags.scan_last) begin
               cmd.respond = 1'b1;
               cmd.code    = ST_FULL;
               state_in    = S_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_WALK: begin
            if (flags.at_target) begin
               cmd.remove_commit = 1'b1;
               cmd.respond       = 1'b1;
               state_in          = S_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/all_datapath.sv]
`timescale 1ns / 1ps

module all_datapath
   import all_pkg::*;
#(
   parameter int STORE_DEPTH = 16,
   parameter int VALUE_BITS  = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_item,
   input  logic                  csr_write,
   input  logic [COUNT_BITS-1:0] csr_data,
   input  cmd_type               cmd,
   output flags_type             flags,
   output logic                  rsp_strobe,
   output rsp_type               rsp_item
);

   // the capacity register never reaches beyond 31 slots
   localparam int USED_DEPTH = (STORE_DEPTH < 31) ? STORE_DEPTH : 31;
   localparam int SLOT_BITS  = $clog2(USED_DEPTH);
   localparam logic [COUNT_BITS-1:0] DEPTH_CAP = COUNT_BITS'(USED_DEPTH);
   localparam logic [COUNT_BITS-1:0] CAP_RESET =
      COUNT_BITS'((USED_DEPTH < 16) ? USED_DEPTH : 16);

   req_type                 req_ff;
   logic [COUNT_BITS-1:0]   cap_ff, cap_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [SLOT_BITS-1:0]    head_ff, head_in;
   logic [SLOT_BITS-1:0]    tail_ff, tail_in;
   logic [USED_DEPTH-1:0]   busy_ff, busy_in;
   logic [SLOT_BITS-1:0]    next_ff [USED_DEPTH];
   logic [VALUE_BITS-1:0]   value_mem [USED_DEPTH];
   logic [SLOT_BITS-1:0]    scan_ff, cur_ff, pred_ff;
   logic [POS_BITS-1:0]     step_ff;
   rsp_type                 rsp_ff, rsp_in;
   logic                    strobe_ff;

   logic                    next_we;
   logic [SLOT_BITS-1:0]    next_addr, next_data;
   logic [SLOT_BITS-1:0]    cur_next;
   logic [COUNT_BITS-1:0]   slot_wide;

   assign cur_next = next_ff[cur_ff];

   always_comb begin
      flags.is_remove = (req_ff.opcode == OP_REMOVE);
      flags.full      = (count_ff >= cap_ff);
      flags.bad_pos   = (COUNT_BITS'(req_ff.list_position) >= count_ff);
      flags.slot_free = !busy_ff[scan_ff];
      flags.scan_last = ((COUNT_BITS'(scan_ff) + COUNT_BITS'(1)) >= cap_ff);
      flags.at_target = (step_ff == req_ff.list_position);
   end

   assign cap_in = (csr_data < DEPTH_CAP) ? csr_data : DEPTH_CAP;

   // list update on commit
   always_comb begin
      count_in  = count_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      busy_in   = busy_ff;
      next_we   = 1'b0;
      next_addr = tail_ff;
      next_data = scan_ff;
      if (cmd.append_commit) begin
         busy_in[scan_ff] = 1'b1;
         count_in         = count_ff + COUNT_BITS'(1);
         tail_in          = scan_ff;
         if (count_ff == '0) begin
            head_in = scan_ff;
         end else begin
            next_we = 1'b1;
         end
      end else if (cmd.remove_commit) begin
         busy_in[cur_ff] = 1'b0;
         count_in        = count_ff - COUNT_BITS'(1);
         if (step_ff == '0) begin
            head_in = (count_ff == COUNT_BITS'(1)) ? '0 : cur_next;
         end else begin
            next_we   = 1'b1;
            next_addr = pred_ff;
            next_data = cur_next;
         end
         if (cur_ff == tail_ff) begin
            tail_in = (count_ff == COUNT_BITS'(1)) ? '0 : pred_ff;
         end
      end
   end

   always_comb begin
      slot_wide = '0;
      if (cmd.append_commit) begin
         slot_wide = COUNT_BITS'(scan_ff);
      end else if (cmd.remove_commit) begin
         slot_wide = COUNT_BITS'(cur_ff);
      end
      rsp_in.status      = cmd.code;
      rsp_in.slot_used   = slot_wide[SLOT_BITS_OUT-1:0];
      rsp_in.list_length = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         count_ff  <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         busy_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            cap_ff <= cap_in;
         end
         count_ff  <= count_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         busy_ff   <= busy_in;
         strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_item;
         scan_ff <= '0;
         cur_ff  <= head_ff;
         pred_ff <= '0;
         step_ff <= '0;
      end
      if (cmd.scan_step) begin
         scan_ff <= scan_ff + SLOT_BITS'(1);
      end
      if (cmd.walk_step) begin
         pred_ff <= cur_ff;
         cur_ff  <= cur_next;
         step_ff <= step_ff + POS_BITS'(1);
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_ff[next_addr] <= next_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append_commit) begin
         value_mem[scan_ff] <= VALUE_BITS'(req_ff.item_value);
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   a_busy_matches_count : assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) == int'(count_ff))
      else $error("slot marks disagree with entry count");

   a_error_slot_zero : assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && rsp_ff.status != ST_DONE) |-> (rsp_ff.slot_used == '0))
      else $error("error result carries a slot");

   a_commit_one_hot : assert property (@(posedge clock) disable iff (reset)
      (cmd.append_commit || cmd.remove_commit) |-> (cmd.respond && cmd.code == ST_DONE &&
      !(cmd.append_commit && cmd.remove_commit)))
      else $error("commit without a done result");

   a_append_takes_free : assert property (@(posedge clock) disable iff (reset)
      cmd.append_commit |-> (!busy_ff[scan_ff] && count_ff < cap_ff))
      else $error("append into a used slot");

endmodule

[rtl/core/array_linked_list_engine.sv]
`timescale 1ns / 1ps
// channel   ports                                 direction  item
// request   start, busy, req_item                 in         req_type
// response  rsp_strobe, rsp_item                  out        rsp_type
// csr       csr_valid, csr_ready, csr_data[4:0]   in         capacity
//
// append: answers from the decide state when full, else scans upward for the lowest free slot
// remove: answers from the decide state on a bad position, else walks the links to the position
// the result strobes in the cycle after the last busy cycle
// the free slot scan and link walk read one node per cycle
// synchronous reset frees every slot, empties the list and sets capacity 16, or the store depth if smaller
// the receiver cannot stall: the result strobe is high for a single cycle

module array_linked_list_engine
   import all_pkg::*;
#(
   parameter int STORE_DEPTH = 16,
   parameter int VALUE_BITS  = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_item,
   // result channel
   output logic                  rsp_strobe,
   output rsp_type               rsp_item,
   // capacity register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COUNT_BITS-1:0] csr_data
);

   cmd_type   cmd;
   flags_type flags;

   // capacity is only taken between items
   assign csr_ready = ~busy;

   // sequencer: idle, decide, scan for a free slot or walk the links
   all_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .flags (flags),
      .cmd   (cmd)
   );

   // node store, list registers and the registered result
   all_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .csr_write  (csr_valid & csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .flags      (flags),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
